@@ hdl/stepper_target_follower_assert.svh @@
`ifndef STEPPER_TARGET_FOLLOWER_ASSERT_SVH
`define STEPPER_TARGET_FOLLOWER_ASSERT_SVH

// Shared assertion forms; every user names its clock clk and its reset rst.

// Same-cycle implication.
`define STF_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stf: same-cycle check failed");

// Next-cycle implication.
`define STF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stf: next-cycle check failed");

`endif

@@ hdl/stf_pkg.sv @@
`timescale 1ns / 1ps

package stf_pkg;

  // Field widths
  localparam int TARGET_W   = 24;
  localparam int STEPS_W    = 24;
  localparam int REM_W      = 17;
  localparam int CFG_W      = 16;
  localparam int OUT_DATA_W = 8;

  // Step count = (|diff| * steps_per_rev + carry) / (360 * 256).
  // 92160 = 2^11 * 45, so the divide is a shift and a divide by 45.
  localparam int TOTAL_W   = 41;
  localparam int DIV_SHIFT = 11;
  localparam int QUOT_W    = TOTAL_W - DIV_SHIFT;
  localparam int ODD_W     = 6;
  localparam logic [ODD_W-1:0] DIV_ODD   = 6'd45;
  localparam logic [REM_W-1:0] DEG_UNITS = 17'd92160;

  // Divide by 45 as a multiply by ceil(2^35 / 45) and a shift; the rounding
  // error stays below one for every 30-bit dividend
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP_M = 30'd763549742;

  // Input operation codes
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_REV  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CARRY_FRACTION = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_IDLE_HIGH = 3'd4;

  // Configuration reset values
  localparam logic [CFG_W-1:0] RST_STEPS_PER_REV = 16'd2000;
  localparam logic [CFG_W-1:0] RST_TOLERANCE     = 16'd128;
  localparam logic [CFG_W-1:0] RST_HALF_PERIOD   = 16'd1200;

  // Classified input item
  typedef struct packed {
    logic                       tick;
    logic signed [TARGET_W-1:0] target;
  } item_t;

  // Line state returned for each item, step_out in the lowest bit
  typedef struct packed {
    logic arrived;
    logic busy_res;
    logic dir_out;
    logic step_out;
  } result_t;

endpackage

@@ hdl/stepper_target_follower.sv @@
`timescale 1ns / 1ps
// Single-axis step/direction generator that follows a target angle.
// Input stream: s_tuser selects the item kind (1 = one-microsecond tick,
// 0 = latch s_tdata as the new signed target in 1/256 degree).
// Output stream: one transfer per input item carrying the line state
// after that item: step level, direction, busy and arrived.
// Configuration: cfg_index/cfg_data write a register whenever cfg_valid
// is high (cfg_ready is always high); write only while the block is idle.
// Path: an item passes through the input stage, the queue and the result
// register. A tick that starts a move holds the back end for the multiply
// and compare states; with a nonzero step count a reciprocal divide by 45
// (load, multiply, register) follows.
// Throughput: one item per cycle otherwise, while the receiver keeps m_tready high.
// Reset: control, axis and configuration state return to reset values,
// data registers do not reset. A stalled receiver holds the result; the
// queue then fills and s_tready drops once the queue and the input stage are full.

module stepper_target_follower #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [stf_pkg::TARGET_W-1:0]     s_tdata,   // [23:0] target
  input  logic                             s_tuser,   // [0] operation
  // Output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [stf_pkg::OUT_DATA_W-1:0]   m_tdata,   // [0] step_out, [1] dir_out,
                                                      // [2] busy_res, [3] arrived
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [stf_pkg::CFG_W-1:0]        cfg_data
);

  logic           q_push, q_full, q_pop, q_empty;
  stf_pkg::item_t push_item, pop_item;

  assign cfg_ready = 1'b1;

  stf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  stf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  stf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ hdl/stf_front.sv @@
`timescale 1ns / 1ps

module stf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [stf_pkg::TARGET_W-1:0]  s_tdata,
  input  logic                          s_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output stf_pkg::item_t                q_item
);

  logic           held;
  stf_pkg::item_t item;
  logic           accept;

  // Take a new item whenever the stage is empty or drains this cycle
  assign s_tready = !held || !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = held;
  assign q_item   = item;

  // Hold one classified item until the queue has room
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (!q_full) begin
      held <= 1'b0;
    end
    if (accept) begin
      item.tick   <= (s_tuser == stf_pkg::OP_TICK);
      item.target <= signed'(s_tdata);
    end
  end

endmodule

@@ hdl/stf_fifo.sv @@
`timescale 1ns / 1ps
`include "stepper_target_follower_assert.svh"

module stf_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  stf_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output stf_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  stf_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots[rd_ptr];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `STF_ASSERT_IMPLY(a_empty_pointers_meet, count == '0, wr_ptr == rd_ptr)

endmodule

@@ hdl/stf_div.sv @@
`timescale 1ns / 1ps
`include "stepper_target_follower_assert.svh"

module stf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [stf_pkg::TOTAL_W-1:0]  dividend,
  output logic                         busy,
  output logic                         done,
  output logic [stf_pkg::STEPS_W-1:0]  quotient,
  output logic [stf_pkg::REM_W-1:0]    remainder
);

  localparam int PROD_W = stf_pkg::QUOT_W + stf_pkg::RECIP_W;
  localparam int QW     = PROD_W - stf_pkg::RECIP_SHIFT;

  logic [stf_pkg::QUOT_W-1:0]    upper;
  logic [stf_pkg::DIV_SHIFT-1:0] low;
  logic [PROD_W-1:0]             prod;
  logic                          second;
  logic [QW-1:0]                 quot_now;
  logic [stf_pkg::QUOT_W-1:0]    back_mul;
  logic [stf_pkg::QUOT_W-1:0]    rest;
  logic [stf_pkg::STEPS_W-1:0]   quot_q;
  logic [stf_pkg::ODD_W-1:0]     rem_q;

  // Quotient from the reciprocal product; the remainder is what it leaves
  always_comb begin
    quot_now = prod[PROD_W-1:stf_pkg::RECIP_SHIFT];
    back_mul = stf_pkg::QUOT_W'(quot_now) * stf_pkg::QUOT_W'(stf_pkg::DIV_ODD);
    rest     = upper - back_mul;
  end

  // Load, multiply, then register quotient and remainder and raise done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      second <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        second <= 1'b0;
      end else if (busy) begin
        if (second) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          second <= 1'b0;
        end else begin
          second <= 1'b1;
        end
      end
    end
    if (start) begin
      upper <= dividend[stf_pkg::TOTAL_W-1:stf_pkg::DIV_SHIFT];
      low   <= dividend[stf_pkg::DIV_SHIFT-1:0];
    end else if (busy && !second) begin
      prod <= upper * stf_pkg::RECIP_M;
    end else if (busy && second) begin
      quot_q <= quot_now[stf_pkg::STEPS_W-1:0];
      rem_q  <= rest[stf_pkg::ODD_W-1:0];
    end
  end

  assign quotient  = quot_q;
  assign remainder = {rem_q, low};

  `STF_ASSERT_IMPLY(a_no_restart_while_busy, start, !busy)

endmodule

@@ hdl/stf_back.sv @@
`timescale 1ns / 1ps
`include "stepper_target_follower_assert.svh"

module stf_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [stf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [stf_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             q_empty,
  input  stf_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [stf_pkg::OUT_DATA_W-1:0]   m_tdata
);

  typedef enum logic [1:0] {ST_RUN, ST_MUL, ST_CHK, ST_DIV} state_t;

  localparam int TW = stf_pkg::TARGET_W;
  localparam int SW = stf_pkg::STEPS_W;
  localparam int RW = stf_pkg::REM_W;
  localparam int CW = stf_pkg::CFG_W;
  localparam int PW = TW + CW;

  state_t state, state_next;

  // Configuration
  logic [CW-1:0] steps_per_rev, steps_per_rev_next;
  logic [CW-1:0] tolerance, tolerance_next;
  logic [CW-1:0] half_period, half_period_next;
  logic          carry_fraction, carry_fraction_next;
  logic          step_idle_high, step_idle_high_next;

  // Axis state
  logic signed [TW-1:0] position, position_next;
  logic signed [TW-1:0] pending_target, pending_target_next;
  logic signed [TW-1:0] move_target, move_target_next;
  logic [SW-1:0]        steps_left, steps_left_next;
  logic [CW-1:0]        half_count, half_count_next;
  logic                 pulse_phase, pulse_phase_next;
  logic [RW-1:0]        step_remainder, step_remainder_next;
  logic                 direction, direction_next;
  logic                 moving, moving_next;

  // Move set-up payload
  logic [TW-1:0] mag, mag_next;
  logic [PW-1:0] product, product_next;

  // Result register
  logic              out_valid, out_valid_next;
  stf_pkg::result_t  out_res, out_res_next;
  stf_pkg::result_t  res;

  // Working signals
  logic                          ready_out, take, load_out, arr;
  logic signed [TW:0]            diff;
  logic [TW:0]                   diff_abs;
  logic [TW-1:0]                 mag_now;
  logic [CW-1:0]                 hp;
  logic [CW:0]                   half_inc;
  logic [RW-1:0]                 carry;
  logic [stf_pkg::TOTAL_W-1:0]   total;
  logic                          zero_steps;
  logic [SW-1:0]                 steps_dec;

  // Divider
  logic          div_start, div_busy, div_done;
  logic [SW-1:0] div_quot;
  logic [RW-1:0] div_rem;

  stf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (total),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign ready_out = !out_valid || m_tready;
  assign take      = (state == ST_RUN) && !q_empty && ready_out;
  assign q_pop     = take;
  assign m_tvalid  = out_valid;
  assign m_tdata   = stf_pkg::OUT_DATA_W'(out_res);

  // Distance to the pending target and the step-count numerator
  always_comb begin
    diff       = {pending_target[TW-1], pending_target} - {position[TW-1], position};
    diff_abs   = diff[TW] ? -diff : diff;
    mag_now    = diff_abs[TW-1:0];
    hp         = (half_period == '0) ? CW'(1) : half_period;
    half_inc   = {1'b0, half_count} + (CW + 1)'(1);
    carry      = carry_fraction ? step_remainder : '0;
    total      = {1'b0, product} + stf_pkg::TOTAL_W'(carry);
    zero_steps = (total < stf_pkg::TOTAL_W'(stf_pkg::DEG_UNITS));
    steps_dec  = (steps_left != '0) ? steps_left - SW'(1) : steps_left;
  end

  // Next state
  always_comb begin
    state_next          = state;
    steps_per_rev_next  = steps_per_rev;
    tolerance_next      = tolerance;
    half_period_next    = half_period;
    carry_fraction_next = carry_fraction;
    step_idle_high_next = step_idle_high;
    position_next       = position;
    pending_target_next = pending_target;
    move_target_next    = move_target;
    steps_left_next     = steps_left;
    half_count_next     = half_count;
    pulse_phase_next    = pulse_phase;
    step_remainder_next = step_remainder;
    direction_next      = direction;
    moving_next         = moving;
    mag_next            = mag;
    product_next        = product;
    load_out            = 1'b0;
    arr                 = 1'b0;
    div_start           = 1'b0;

    // Register writes
    if (cfg_valid) begin
      case (cfg_index)
        stf_pkg::REG_STEPS_PER_REV:  steps_per_rev_next  = cfg_data;
        stf_pkg::REG_TOLERANCE:      tolerance_next      = cfg_data;
        stf_pkg::REG_HALF_PERIOD:    half_period_next    = cfg_data;
        stf_pkg::REG_CARRY_FRACTION: carry_fraction_next = cfg_data[0];
        stf_pkg::REG_STEP_IDLE_HIGH: step_idle_high_next = cfg_data[0];
        default: ;
      endcase
    end

    case (state)
      ST_RUN: begin
        if (take) begin
          if (!q_item.tick) begin
            // Latch the target for the next move
            pending_target_next = q_item.target;
            load_out            = 1'b1;
          end else if (moving) begin
            // Advance the pulse train by one tick
            load_out = 1'b1;
            if (half_inc < {1'b0, hp}) begin
              half_count_next = half_inc[CW-1:0];
            end else begin
              half_count_next = '0;
              if (pulse_phase) begin
                pulse_phase_next = 1'b0;
              end else begin
                steps_left_next = steps_dec;
                if (steps_dec == '0) begin
                  moving_next   = 1'b0;
                  position_next = move_target;
                  arr           = 1'b1;
                end else begin
                  pulse_phase_next = 1'b1;
                end
              end
            end
          end else if (mag_now <= TW'(tolerance)) begin
            // Inside the deadband: nothing to do
            load_out = 1'b1;
          end else begin
            direction_next   = !diff[TW];
            move_target_next = pending_target;
            mag_next         = mag_now;
            state_next       = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        product_next = mag * steps_per_rev;
        state_next   = ST_CHK;
      end
      ST_CHK: begin
        if (zero_steps) begin
          // Less than one step: arrive at once
          if (carry_fraction) begin
            step_remainder_next = total[RW-1:0];
          end
          position_next = move_target;
          arr           = 1'b1;
          load_out      = 1'b1;
          state_next    = ST_RUN;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          steps_left_next = div_quot;
          if (carry_fraction) begin
            step_remainder_next = div_rem;
          end
          half_count_next  = '0;
          pulse_phase_next = 1'b1;
          moving_next      = 1'b1;
          load_out         = 1'b1;
          state_next       = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase

    res.step_out = step_idle_high ^ pulse_phase_next;
    res.dir_out  = direction_next;
    res.busy_res = moving_next;
    res.arrived  = arr;

    // Output register: load a result or drop the one taken
    if (load_out) begin
      out_valid_next = 1'b1;
      out_res_next   = res;
    end else begin
      out_valid_next = out_valid && !m_tready;
      out_res_next   = out_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_RUN;
      steps_per_rev  <= stf_pkg::RST_STEPS_PER_REV;
      tolerance      <= stf_pkg::RST_TOLERANCE;
      half_period    <= stf_pkg::RST_HALF_PERIOD;
      carry_fraction <= 1'b0;
      step_idle_high <= 1'b1;
      position       <= '0;
      pending_target <= '0;
      move_target    <= '0;
      steps_left     <= '0;
      half_count     <= '0;
      pulse_phase    <= 1'b0;
      step_remainder <= '0;
      direction      <= 1'b0;
      moving         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      steps_per_rev  <= steps_per_rev_next;
      tolerance      <= tolerance_next;
      half_period    <= half_period_next;
      carry_fraction <= carry_fraction_next;
      step_idle_high <= step_idle_high_next;
      position       <= position_next;
      pending_target <= pending_target_next;
      move_target    <= move_target_next;
      steps_left     <= steps_left_next;
      half_count     <= half_count_next;
      pulse_phase    <= pulse_phase_next;
      step_remainder <= step_remainder_next;
      direction      <= direction_next;
      moving         <= moving_next;
      out_valid      <= out_valid_next;
    end
    mag     <= mag_next;
    product <= product_next;
    out_res <= out_res_next;
  end

  `STF_ASSERT_IMPLY(a_moving_has_steps, moving, steps_left != '0)
  `STF_ASSERT_IMPLY(a_setup_keeps_output_free, state != ST_RUN, !out_valid)
  `STF_ASSERT_IMPLY(a_arrival_not_busy, out_valid && out_res.arrived, !out_res.busy_res)
  `STF_ASSERT_NEXT(a_divide_starts_move, div_done, (state == ST_RUN) && moving && !div_busy)

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam logic   OP_LATCH      = ~stf_pkg::OP_TICK;
  localparam longint DEG           = longint'(stf_pkg::DEG_UNITS);
  localparam int     RANDOM_ITEMS  = 1000;
  localparam int     PHASE_ITEMS   = 150;
  localparam int     SETTLE_CYCLES = 48;
  localparam int     CYCLE_LIMIT   = 1000000;
  localparam longint TARGET_MAX    = 64'sd8388607;
  localparam longint TARGET_MIN    = -64'sd8388608;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [stf_pkg::TARGET_W-1:0]    s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [stf_pkg::OUT_DATA_W-1:0]  m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [stf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [stf_pkg::CFG_W-1:0]       cfg_data = '0;

  stepper_target_follower dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Follower copy: configuration
  int unsigned cfg_spr       = 32'(stf_pkg::RST_STEPS_PER_REV);
  int unsigned cfg_tol       = 32'(stf_pkg::RST_TOLERANCE);
  int unsigned cfg_hp        = 32'(stf_pkg::RST_HALF_PERIOD);
  bit          cfg_carry     = 1'b0;
  bit          cfg_idle_high = 1'b1;

  // Follower copy: axis state
  logic signed [stf_pkg::TARGET_W-1:0] at_pos   = '0;
  logic signed [stf_pkg::TARGET_W-1:0] pend_tgt = '0;
  logic signed [stf_pkg::TARGET_W-1:0] move_tgt = '0;
  int unsigned steps_left   = 0;
  int unsigned half_cnt     = 0;
  longint      step_rem     = 0;
  bit          phase_active = 1'b0;
  bit          dir_up       = 1'b0;
  bit          moving       = 1'b0;

  // Line states still owed by the block, oldest first
  stf_pkg::result_t expected_lines[$];
  stf_pkg::result_t want;
  stf_pkg::result_t got;

  int          fail_count    = 0;
  int          items_sent    = 0;
  int          lines_checked = 0;
  int          moves_started = 0;
  int          arrivals      = 0;
  int          phases        = 0;
  int          cycle_count   = 0;
  int unsigned reach         = 1;
  int unsigned reach_tol     = 0;
  bit          send_steady   = 1'b0;
  int          rx_hold       = 0;
  bit          rx_steady     = 1'b0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Advance the follower by one item and return the line state after it
  function automatic stf_pkg::result_t follow_item(input logic op,
      input logic signed [stf_pkg::TARGET_W-1:0] tgt);
    longint           diff;
    longint           mag;
    longint           total;
    longint           nsteps;
    int unsigned      hp_eff;
    stf_pkg::result_t r;
    r = '0;
    if (op != stf_pkg::OP_TICK) begin
      pend_tgt = tgt;
    end else if (moving) begin
      hp_eff = (cfg_hp == 0) ? 1 : cfg_hp;
      if (half_cnt + 1 < hp_eff) begin
        half_cnt = half_cnt + 1;
      end else begin
        half_cnt = 0;
        if (phase_active) begin
          phase_active = 1'b0;
        end else begin
          if (steps_left != 0) steps_left = steps_left - 1;
          if (steps_left == 0) begin
            moving = 1'b0;
            at_pos = move_tgt;
            r.arrived = 1'b1;
            arrivals++;
          end else begin
            phase_active = 1'b1;
          end
        end
      end
    end else begin
      // Idle tick: start a move once outside the deadband
      diff = longint'(pend_tgt) - longint'(at_pos);
      mag  = (diff < 0) ? -diff : diff;
      if (mag > longint'(cfg_tol)) begin
        dir_up = (diff > 0);
        total  = mag * longint'(cfg_spr) + (cfg_carry ? step_rem : 64'sd0);
        nsteps = total / DEG;
        if (cfg_carry) step_rem = total % DEG;
        move_tgt = pend_tgt;
        if (nsteps == 0) begin
          at_pos = move_tgt;
          r.arrived = 1'b1;
          arrivals++;
        end else begin
          steps_left   = 32'(nsteps);
          half_cnt     = 0;
          phase_active = 1'b1;
          moving       = 1'b1;
          moves_started++;
        end
      end
    end
    r.step_out = phase_active ? ~cfg_idle_high : cfg_idle_high;
    r.dir_out  = dir_up;
    r.busy_res = moving;
    return r;
  endfunction

  // Position the axis will settle at before any new target is taken
  function automatic logic signed [stf_pkg::TARGET_W-1:0] follow_base();
    return moving ? move_tgt : at_pos;
  endfunction

  // Target a short, bounded move away from where the axis is heading
  function automatic logic signed [stf_pkg::TARGET_W-1:0] near_target();
    longint t;
    longint off;
    t   = longint'(follow_base());
    off = longint'($urandom_range(0, reach)) + longint'(reach_tol);
    if ($urandom_range(0, 1) == 1) t = t + off;
    else t = t - off;
    if (t > TARGET_MAX) t = TARGET_MAX;
    if (t < TARGET_MIN) t = TARGET_MIN;
    return t[stf_pkg::TARGET_W-1:0];
  endfunction

  // Sender gap: mostly none, some short, a few long
  function automatic int send_gap();
    int r;
    if (send_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until the transfer, then maybe pause
  task automatic send_item(input logic op, input logic [stf_pkg::TARGET_W-1:0] data);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_lines.push_back(follow_item(op, data));
    items_sent++;
    gap = send_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_item(stf_pkg::OP_TICK, stf_pkg::TARGET_W'($urandom_range(0, 24'hFFFFFF)));
  endtask

  // Tick until the running move, if any, has finished
  task automatic tick_until_idle();
    send_tick();
    while (moving) send_tick();
  endtask

  // Drop valid and wait until every owed line state has been seen
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [stf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [stf_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      stf_pkg::REG_STEPS_PER_REV:  cfg_spr       = 32'(data);
      stf_pkg::REG_TOLERANCE:      cfg_tol       = 32'(data);
      stf_pkg::REG_HALF_PERIOD:    cfg_hp        = 32'(data);
      stf_pkg::REG_CARRY_FRACTION: cfg_carry     = data[0];
      stf_pkg::REG_STEP_IDLE_HIGH: cfg_idle_high = data[0];
      default: ;
    endcase
  endtask

  // Write every register once the block has gone quiet
  task automatic set_config(input int unsigned spr, input int unsigned tol,
                            input int unsigned hp, input bit carry, input bit idle_high);
    settle();
    write_reg(stf_pkg::REG_STEPS_PER_REV, spr[stf_pkg::CFG_W-1:0]);
    write_reg(stf_pkg::REG_TOLERANCE, tol[stf_pkg::CFG_W-1:0]);
    write_reg(stf_pkg::REG_HALF_PERIOD, hp[stf_pkg::CFG_W-1:0]);
    // Single-bit registers: random upper bits are ignored
    write_reg(stf_pkg::REG_CARRY_FRACTION,
              stf_pkg::CFG_W'(($urandom_range(0, 16'hFFFF) & 16'hFFFE) | carry));
    write_reg(stf_pkg::REG_STEP_IDLE_HIGH,
              stf_pkg::CFG_W'(($urandom_range(0, 16'hFFFF) & 16'hFFFE) | idle_high));
    cfg_valid <= 1'b0;
    phases++;
  endtask

  // Reset values: deadband edge and latches of both extreme targets
  task automatic test_reset_defaults();
    send_tick();
    send_item(OP_LATCH, 24'd128);
    send_tick();
    send_item(OP_LATCH, 24'h800000);
    send_item(OP_LATCH, 24'h7FFFFF);
    send_item(OP_LATCH, -24'sd128);
    send_tick();
  endtask

  // Zero steps per rev: every move lands at once, extremes and full deadband
  task automatic test_zero_step_extremes();
    set_config(0, 0, 1, 1'b1, 1'b0);
    send_item(OP_LATCH, 24'h800000);
    send_tick();
    send_item(OP_LATCH, 24'h7FFFFF);
    send_tick();
    set_config(0, 65535, 1, 1'b1, 1'b0);
    send_item(OP_LATCH, 24'h7F0000);
    send_tick();
    send_item(OP_LATCH, 24'h7EFFFF);
    send_tick();
  endtask

  // Full steps per rev, half period of zero, new target during a move
  task automatic test_short_moves();
    logic signed [stf_pkg::TARGET_W-1:0] p;
    set_config(65535, 0, 0, 1'b0, 1'b1);
    send_item(OP_LATCH, at_pos + 24'sd2);
    tick_until_idle();
    p = at_pos;
    send_item(OP_LATCH, p - 24'sd3);
    send_tick();
    send_item(OP_LATCH, p + 24'sd4);
    tick_until_idle();
  endtask

  // Carried remainder across moves, then the longest half period
  task automatic test_carry_remainder();
    logic signed [stf_pkg::TARGET_W-1:0] p;
    set_config(1000, 0, 1, 1'b1, 1'b0);
    p = at_pos;
    send_item(OP_LATCH, p + 24'sd100);
    tick_until_idle();
    send_item(OP_LATCH, p + 24'sd200);
    tick_until_idle();
    send_item(OP_LATCH, p + 24'sd100);
    tick_until_idle();
    set_config(65535, 0, 65535, 1'b0, 1'b1);
    send_item(OP_LATCH, at_pos - 24'sd2);
    send_tick();
    send_tick();
  endtask

  // Random phases: mostly complete moves, some cut short, some noise
  task automatic test_random_moves();
    int unsigned spr;
    int unsigned tol;
    int unsigned hp;
    int unsigned max_steps;
    longint      span;
    int          stop_all;
    int          stop_phase;
    int          kind;
    stop_all = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_all) begin
      case ($urandom_range(0, 9))
        0: spr = 0;
        1: spr = 65535;
        2: spr = 1;
        3: spr = $urandom_range(1, 65535);
        default: spr = $urandom_range(1, 4000);
      endcase
      case ($urandom_range(0, 9))
        0: hp = 0;
        1: hp = 12;
        default: hp = $urandom_range(1, 4);
      endcase
      // Bound the reach to max_steps steps (6 above a half period of 4, else 20)
      max_steps = (hp > 4) ? 6 : 20;
      span = (spr == 0) ? (64'sd1 << 20) : (longint'(max_steps) * DEG) / spr;
      if (span < 1) span = 1;
      if (span > TARGET_MAX) span = TARGET_MAX;
      reach = 32'(span);
      case ($urandom_range(0, 9))
        0: tol = 0;
        1: tol = 65535;
        default: tol = $urandom_range(0, reach);
      endcase
      reach_tol = (tol <= reach) ? tol : 0;
      set_config(spr, tol, hp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_steady = ($urandom_range(0, 3) == 0);
      // Realign the pending target before the new scale applies
      send_item(OP_LATCH, follow_base());
      stop_phase = items_sent + PHASE_ITEMS;
      while (items_sent < stop_phase && items_sent < stop_all) begin
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          send_item(OP_LATCH, near_target());
          tick_until_idle();
          repeat ($urandom_range(0, 2)) send_tick();
        end else if (kind == 7) begin
          send_item(OP_LATCH, near_target());
          repeat ($urandom_range(1, 8)) send_tick();
          send_item(OP_LATCH, near_target());
        end else if (kind == 8) begin
          send_item(OP_LATCH, stf_pkg::TARGET_W'($urandom_range(0, 24'hFFFFFF)));
          send_item(OP_LATCH, near_target());
        end else begin
          repeat ($urandom_range(1, 4)) send_tick();
        end
      end
    end
  endtask

  // Receiver: random stalls, mostly short, with steady stretches
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else if (rx_steady || $urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      rx_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
    if ($urandom_range(0, 299) == 0) rx_steady <= ~rx_steady;
  end

  task automatic check_field(input string name, input logic [3:0] exp_v, input logic [3:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare each output transfer with the oldest owed line state
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_lines.size() == 0) begin
        $error("output transfer with nothing owed: m_tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = expected_lines.pop_front();
        got  = m_tdata[3:0];
        check_field("step_out", 4'(want.step_out), 4'(got.step_out));
        check_field("dir_out", 4'(want.dir_out), 4'(got.dir_out));
        check_field("busy_res", 4'(want.busy_res), 4'(got.busy_res));
        check_field("arrived", 4'(want.arrived), 4'(got.arrived));
        check_field("tdata_pad", 4'd0, m_tdata[7:4]);
        lines_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d line states still owed",
             cycle_count, expected_lines.size());
      $display("status: fail");
      $finish;
    end
  end

  // Sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_step_extremes();
    test_short_moves();
    test_carry_remainder();
    test_random_moves();
    settle();
    $display("run: %0d items, %0d line states checked, %0d stepped moves, %0d arrivals",
             items_sent, lines_checked, moves_started, arrivals);
    $display("run: %0d register settings incl. zero and full-scale values", phases);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
